// File: design/cnp_pkg.sv
// ----------------------------------------------------------------------------
// cnp_pkg
// shared types, constants and tag tables of the common name parser
// ----------------------------------------------------------------------------
`default_nettype none

package cnp_pkg;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] UUID_LEN    = 6'd36;
    localparam logic [POS_W-1:0] TAG_LEN     = 6'd9;
    localparam logic [POS_W-1:0] TAG_PFX_LEN = 6'd5;
    localparam logic [POS_W-1:0] POS_MAX     = 6'd63;

    localparam logic [POS_W-1:0] HYPHEN_POS_0 = 6'd8;
    localparam logic [POS_W-1:0] HYPHEN_POS_1 = 6'd13;
    localparam logic [POS_W-1:0] HYPHEN_POS_2 = 6'd18;
    localparam logic [POS_W-1:0] HYPHEN_POS_3 = 6'd23;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_F   = 8'h66;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_F   = 8'h46;
    localparam logic [7:0] CHAR_UC_B   = 8'h42;
    localparam logic [7:0] CHAR_UC_C   = 8'h43;
    localparam logic [7:0] CHAR_UC_D   = 8'h44;
    localparam logic [7:0] CHAR_UC_I   = 8'h49;
    localparam logic [7:0] CHAR_UC_P   = 8'h50;

    localparam int unsigned OUT_DATA_W = 168;

    typedef struct packed {
        logic       is_zero;
        logic       is_space;
        logic       is_hyphen;
        logic       is_hex;
        logic [3:0] hex_val;
    } char_class_t;

    typedef struct packed {
        logic        status;
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic        has_cid_pid;
        logic [15:0] company_id;
        logic [15:0] product_id;
    } verdict_t;

    // "BCID:" by position
    function automatic logic [7:0] cid_tag_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CHAR_UC_B;
            3'd1:    ch = CHAR_UC_C;
            3'd2:    ch = CHAR_UC_I;
            3'd3:    ch = CHAR_UC_D;
            3'd4:    ch = CHAR_COLON;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

    // "BPID:" by position
    function automatic logic [7:0] pid_tag_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CHAR_UC_B;
            3'd1:    ch = CHAR_UC_P;
            3'd2:    ch = CHAR_UC_I;
            3'd3:    ch = CHAR_UC_D;
            3'd4:    ch = CHAR_COLON;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: design/cnp_char_class.sv
// ----------------------------------------------------------------------------
// cnp_char_class
// classifies one text byte: end of text, white space, hyphen, hex digit
// ----------------------------------------------------------------------------
`default_nettype none

module cnp_char_class
    import cnp_pkg::*;
(
    input  wire logic [7:0]  name_char,
    output char_class_t      cls
);

    logic       is_dec;
    logic       is_lc;
    logic       is_uc;
    logic [7:0] dec_off;
    logic [7:0] lc_off;
    logic [7:0] uc_off;

    always_comb
    begin
        is_dec  = (name_char >= CHAR_0) && (name_char <= CHAR_9);
        is_lc   = (name_char >= CHAR_LC_A) && (name_char <= CHAR_LC_F);
        is_uc   = (name_char >= CHAR_UC_A) && (name_char <= CHAR_UC_F);
        dec_off = name_char - CHAR_0;
        lc_off  = name_char - CHAR_LC_A + 8'd10;
        uc_off  = name_char - CHAR_UC_A + 8'd10;

        cls.is_zero   = (name_char == CHAR_NUL);
        // c-locale white space: space, tab through carriage return
        cls.is_space  = (name_char == CHAR_SPACE) ||
                        ((name_char >= CHAR_TAB) && (name_char <= CHAR_CR));
        cls.is_hyphen = (name_char == CHAR_HYPHEN);
        cls.is_hex    = is_dec || is_lc || is_uc;
        if (is_dec)
        begin
            cls.hex_val = dec_off[3:0];
        end
        else if (is_lc)
        begin
            cls.hex_val = lc_off[3:0];
        end
        else
        begin
            cls.hex_val = uc_off[3:0];
        end
    end

endmodule

`default_nettype wire

// File: design/cnp_token_parser.sv
// ----------------------------------------------------------------------------
// cnp_token_parser
// per-byte token state, token close and verdict of one common name
// ----------------------------------------------------------------------------
`default_nettype none

module cnp_token_parser
    import cnp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  name_char,
    input  wire logic        last_char,
    input  wire char_class_t cls,
    output verdict_t         verdict
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             shape_uuid_reg, shape_uuid_next;
    logic             shape_bcid_reg, shape_bcid_next;
    logic             shape_bpid_reg, shape_bpid_next;
    logic [127:0]     nib_reg, nib_next;
    logic [127:0]     kept_uuid_reg, kept_uuid_next;
    logic             seen_uuid_reg, seen_uuid_next;
    logic             seen_cid_reg, seen_cid_next;
    logic             seen_pid_reg, seen_pid_next;
    logic [15:0]      kept_cid_reg, kept_cid_next;
    logic [15:0]      kept_pid_reg, kept_pid_next;
    logic             err_reg, err_next;
    logic             ended_reg, ended_next;

    // token state after the byte is taken
    logic             take;
    logic             close;
    logic [POS_W-1:0] pos1;
    logic             shape_uuid1, shape_bcid1, shape_bpid1;
    logic [127:0]     nib1;
    logic             uuid_ok, bcid_ok, bpid_ok;
    logic             hyphen_slot;
    // token-level outcome after a close
    logic [127:0]     kept_uuid2;
    logic             seen_uuid2, seen_cid2, seen_pid2;
    logic [15:0]      kept_cid2, kept_pid2;
    logic             err2;
    logic             bad;

    always_comb
    begin
        take  = !ended_reg && !cls.is_zero && !cls.is_space;
        close = last_char || (!ended_reg && (cls.is_zero || cls.is_space));

        hyphen_slot = (pos_reg == HYPHEN_POS_0) || (pos_reg == HYPHEN_POS_1) ||
                      (pos_reg == HYPHEN_POS_2) || (pos_reg == HYPHEN_POS_3);
        if (pos_reg < UUID_LEN)
        begin
            uuid_ok = hyphen_slot ? cls.is_hyphen : cls.is_hex;
        end
        else
        begin
            uuid_ok = 1'b0;
        end

        if (pos_reg < TAG_PFX_LEN)
        begin
            bcid_ok = (name_char == cid_tag_char(pos_reg[2:0]));
            bpid_ok = (name_char == pid_tag_char(pos_reg[2:0]));
        end
        else if (pos_reg < TAG_LEN)
        begin
            bcid_ok = cls.is_hex;
            bpid_ok = cls.is_hex;
        end
        else
        begin
            bcid_ok = 1'b0;
            bpid_ok = 1'b0;
        end

        pos1        = pos_reg;
        shape_uuid1 = shape_uuid_reg;
        shape_bcid1 = shape_bcid_reg;
        shape_bpid1 = shape_bpid_reg;
        nib1        = nib_reg;
        if (take)
        begin
            shape_uuid1 = shape_uuid_reg & uuid_ok;
            shape_bcid1 = shape_bcid_reg & bcid_ok;
            shape_bpid1 = shape_bpid_reg & bpid_ok;
            if (cls.is_hex)
            begin
                nib1 = {nib_reg[123:0], cls.hex_val};
            end
            if (pos_reg != POS_MAX)
            begin
                pos1 = pos_reg + 6'd1;
            end
        end

        kept_uuid2 = kept_uuid_reg;
        seen_uuid2 = seen_uuid_reg;
        seen_cid2  = seen_cid_reg;
        seen_pid2  = seen_pid_reg;
        kept_cid2  = kept_cid_reg;
        kept_pid2  = kept_pid_reg;
        err2       = err_reg;
        if (close && (pos1 != '0))
        begin
            if (!seen_uuid_reg && shape_uuid1 && (pos1 == UUID_LEN))
            begin
                kept_uuid2 = nib1;
                seen_uuid2 = 1'b1;
            end
            else if (shape_bcid1 && (pos1 == TAG_LEN))
            begin
                if (seen_cid_reg)
                begin
                    err2 = 1'b1;
                end
                else
                begin
                    kept_cid2 = nib1[15:0];
                    seen_cid2 = 1'b1;
                end
            end
            else if (shape_bpid1 && (pos1 == TAG_LEN))
            begin
                if (seen_pid_reg)
                begin
                    err2 = 1'b1;
                end
                else
                begin
                    kept_pid2 = nib1[15:0];
                    seen_pid2 = 1'b1;
                end
            end
            else
            begin
                err2 = 1'b1;
            end
        end

        bad = err2 || !seen_uuid2 || (seen_cid2 != seen_pid2);
        verdict.status      = bad;
        verdict.uuid_high   = bad ? 64'd0 : kept_uuid2[127:64];
        verdict.uuid_low    = bad ? 64'd0 : kept_uuid2[63:0];
        verdict.has_cid_pid = !bad && seen_cid2 && seen_pid2;
        verdict.company_id  = bad ? 16'd0 : kept_cid2;
        verdict.product_id  = bad ? 16'd0 : kept_pid2;

        pos_next        = pos_reg;
        shape_uuid_next = shape_uuid_reg;
        shape_bcid_next = shape_bcid_reg;
        shape_bpid_next = shape_bpid_reg;
        nib_next        = nib_reg;
        kept_uuid_next  = kept_uuid_reg;
        seen_uuid_next  = seen_uuid_reg;
        seen_cid_next   = seen_cid_reg;
        seen_pid_next   = seen_pid_reg;
        kept_cid_next   = kept_cid_reg;
        kept_pid_next   = kept_pid_reg;
        err_next        = err_reg;
        ended_next      = ended_reg;
        if (step)
        begin
            if (last_char)
            begin
                // verdict given, whole parse state starts over
                pos_next        = '0;
                shape_uuid_next = 1'b1;
                shape_bcid_next = 1'b1;
                shape_bpid_next = 1'b1;
                nib_next        = '0;
                kept_uuid_next  = '0;
                seen_uuid_next  = 1'b0;
                seen_cid_next   = 1'b0;
                seen_pid_next   = 1'b0;
                kept_cid_next   = '0;
                kept_pid_next   = '0;
                err_next        = 1'b0;
                ended_next      = 1'b0;
            end
            else
            begin
                if (close)
                begin
                    pos_next        = '0;
                    shape_uuid_next = 1'b1;
                    shape_bcid_next = 1'b1;
                    shape_bpid_next = 1'b1;
                    nib_next        = '0;
                end
                else
                begin
                    pos_next        = pos1;
                    shape_uuid_next = shape_uuid1;
                    shape_bcid_next = shape_bcid1;
                    shape_bpid_next = shape_bpid1;
                    nib_next        = nib1;
                end
                kept_uuid_next = kept_uuid2;
                seen_uuid_next = seen_uuid2;
                seen_cid_next  = seen_cid2;
                seen_pid_next  = seen_pid2;
                kept_cid_next  = kept_cid2;
                kept_pid_next  = kept_pid2;
                err_next       = err2;
                ended_next     = ended_reg || cls.is_zero;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            shape_uuid_reg <= 1'b1;
            shape_bcid_reg <= 1'b1;
            shape_bpid_reg <= 1'b1;
            nib_reg        <= '0;
            kept_uuid_reg  <= '0;
            seen_uuid_reg  <= 1'b0;
            seen_cid_reg   <= 1'b0;
            seen_pid_reg   <= 1'b0;
            kept_cid_reg   <= '0;
            kept_pid_reg   <= '0;
            err_reg        <= 1'b0;
            ended_reg      <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            shape_uuid_reg <= shape_uuid_next;
            shape_bcid_reg <= shape_bcid_next;
            shape_bpid_reg <= shape_bpid_next;
            nib_reg        <= nib_next;
            kept_uuid_reg  <= kept_uuid_next;
            seen_uuid_reg  <= seen_uuid_next;
            seen_cid_reg   <= seen_cid_next;
            seen_pid_reg   <= seen_pid_next;
            kept_cid_reg   <= kept_cid_next;
            kept_pid_reg   <= kept_pid_next;
            err_reg        <= err_next;
            ended_reg      <= ended_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cert_common_name_parser_top.sv
// result: the verdict of a name is valid once its last item, accepted into the
// input register, has moved on into the result register
// throughput: one item per cycle; only a held result with tready low stalls
// the next last-marked item in the input register
// reset: rst_n asynchronous active low; clears all parse state and both
// valid flags, no clearing pass
// ----------------------------------------------------------------------------
// cert_common_name_parser_top
// splits a common name into tokens and gives one verdict per name
// ----------------------------------------------------------------------------
`default_nettype none

module cert_common_name_parser_top
    import cnp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // name_char
    input  wire logic                  s_axis_tlast,  // last_char
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status, uuid_high, uuid_low, has_cid_pid, company_id, product_id, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    verdict_t    out_reg;
    logic        fire;
    char_class_t cls;
    verdict_t    verdict;

    // a last item needs the result register free or draining
    assign fire = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    cnp_char_class u_char_class (
        .name_char (in_char_reg),
        .cls       (cls)
    );

    cnp_token_parser u_token_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .name_char (in_char_reg),
        .last_char (in_last_reg),
        .cls       (cls),
        .verdict   (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (fire && in_last_reg)
        begin
            out_reg <= verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.product_id, out_reg.company_id,
                            out_reg.has_cid_pid, out_reg.uuid_low,
                            out_reg.uuid_high, out_reg.status};

`ifndef NO_ASSERTIONS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> m_axis_tvalid)
        else $error("last item did not produce a result");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a held result");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_char_reg)
                                     && $stable(in_last_reg)))
        else $error("pending item lost or overwritten");

    a_result_not_clobbered: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

// File: tb/cert_common_name_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cert_common_name_parser_top_tb
// streams common names through the parser and checks every verdict
// ----------------------------------------------------------------------------
// names are built as byte strings: a few hand-picked ones first, then random
// names that are mostly well formed (uuid, tags, white space in random order)
// with some broken, noisy or overlong ones mixed in. an in-bench parser
// predicts each verdict when the last byte is accepted, and the monitor
// compares the output fields in order. both sides idle at random, and the
// receiver holds off once for a long stretch to back the parser up.
// ----------------------------------------------------------------------------

module cert_common_name_parser_top_tb;
    import cnp_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int MIN_BYTES = 700;
    localparam int MIN_NAMES = 40;
    localparam logic [39:0] CID_TAG = {CHAR_COLON, CHAR_UC_D, CHAR_UC_I, CHAR_UC_C, CHAR_UC_B};
    localparam logic [39:0] PID_TAG = {CHAR_COLON, CHAR_UC_D, CHAR_UC_I, CHAR_UC_P, CHAR_UC_B};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } name_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    cert_common_name_parser_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    name_byte_t pending_q[$];
    logic [7:0] name_buf[$];
    verdict_t   verdict_q[$];

    int stim_total = 0;
    int items_done = 0;
    int names_built = 0;
    int verdicts_seen = 0;
    int error_count = 0;

    // parser state of the predictor
    logic [5:0]   tok_len;
    logic         fits_uuid;
    logic         fits_cid;
    logic         fits_pid;
    logic [127:0] tok_hex;
    logic [127:0] uuid_val;
    logic         got_uuid;
    logic         got_cid;
    logic         got_pid;
    logic [15:0]  cid_val;
    logic [15:0]  pid_val;
    logic         bad_token;
    logic         text_done;

    task automatic open_token();
        tok_len = '0;
        fits_uuid = 1'b1;
        fits_cid = 1'b1;
        fits_pid = 1'b1;
        tok_hex = '0;
    endtask

    task automatic clear_parse();
        open_token();
        uuid_val = '0;
        got_uuid = 1'b0;
        got_cid = 1'b0;
        got_pid = 1'b0;
        cid_val = '0;
        pid_val = '0;
        bad_token = 1'b0;
        text_done = 1'b0;
    endtask

    task automatic close_token();
        if (tok_len != 0)
        begin
            if (!got_uuid && fits_uuid && tok_len == UUID_LEN)
            begin
                uuid_val = tok_hex;
                got_uuid = 1'b1;
            end
            else if (fits_cid && tok_len == TAG_LEN)
            begin
                if (got_cid)
                    bad_token = 1'b1;
                else
                begin
                    cid_val = tok_hex[15:0];
                    got_cid = 1'b1;
                end
            end
            else if (fits_pid && tok_len == TAG_LEN)
            begin
                if (got_pid)
                    bad_token = 1'b1;
                else
                begin
                    pid_val = tok_hex[15:0];
                    got_pid = 1'b1;
                end
            end
            else
                bad_token = 1'b1;
            open_token();
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        logic [5:0] p;
        logic       hex_ok;
        logic [7:0] nib;
        p = tok_len;
        hex_ok = 1'b1;
        nib = '0;
        if (c >= CHAR_0 && c <= CHAR_9)
            nib = c - CHAR_0;
        else if (c >= CHAR_LC_A && c <= CHAR_LC_F)
            nib = c - CHAR_LC_A + 8'd10;
        else if (c >= CHAR_UC_A && c <= CHAR_UC_F)
            nib = c - CHAR_UC_A + 8'd10;
        else
            hex_ok = 1'b0;

        if (p < UUID_LEN)
        begin
            if (p == HYPHEN_POS_0 || p == HYPHEN_POS_1 || p == HYPHEN_POS_2
                || p == HYPHEN_POS_3)
            begin
                if (c != CHAR_HYPHEN)
                    fits_uuid = 1'b0;
            end
            else if (!hex_ok)
                fits_uuid = 1'b0;
        end
        else
            fits_uuid = 1'b0;

        if (p < TAG_PFX_LEN)
        begin
            if (c != CID_TAG[p*8 +: 8])
                fits_cid = 1'b0;
            if (c != PID_TAG[p*8 +: 8])
                fits_pid = 1'b0;
        end
        else if (p < TAG_LEN)
        begin
            if (!hex_ok)
            begin
                fits_cid = 1'b0;
                fits_pid = 1'b0;
            end
        end
        else
        begin
            fits_cid = 1'b0;
            fits_pid = 1'b0;
        end

        if (hex_ok)
            tok_hex = {tok_hex[123:0], nib[3:0]};
        if (p < POS_MAX)
            tok_len = p + 6'd1;
    endtask

    // advance the predictor by one accepted item, queue a verdict on the last one
    task automatic parse_item(input logic [7:0] c, input logic last);
        verdict_t v;
        logic     bad;
        if (!text_done)
        begin
            if (c == CHAR_NUL)
            begin
                close_token();
                text_done = 1'b1;
            end
            else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                close_token();
            else
                scan_char(c);
        end
        if (last)
        begin
            close_token();
            bad = bad_token || !got_uuid || (got_cid != got_pid);
            v.status = bad;
            v.uuid_high = bad ? 64'd0 : uuid_val[127:64];
            v.uuid_low = bad ? 64'd0 : uuid_val[63:0];
            v.has_cid_pid = !bad && got_cid && got_pid;
            v.company_id = bad ? 16'd0 : cid_val;
            v.product_id = bad ? 16'd0 : pid_val;
            verdict_q.push_back(v);
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------
    // name building
    // ------------------------------------------------------------------
    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
    endtask

    task automatic put_hex(input int n);
        logic [7:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = 8'($urandom_range(0, 15));
            if (v < 10)
                name_buf.push_back(CHAR_0 + v);
            else if ($urandom_range(0, 1) == 1)
                name_buf.push_back(CHAR_UC_A + v - 8'd10);
            else
                name_buf.push_back(CHAR_LC_A + v - 8'd10);
        end
    endtask

    task automatic put_sep();
        int r;
        for (int i = $urandom_range(1, 3); i > 0; i--)
        begin
            r = $urandom_range(0, 5);
            name_buf.push_back(r == 5 ? CHAR_SPACE : CHAR_TAB + 8'(r));
        end
    endtask

    task automatic put_uuid();
        put_hex(8);
        name_buf.push_back(CHAR_HYPHEN);
        put_hex(4);
        name_buf.push_back(CHAR_HYPHEN);
        put_hex(4);
        name_buf.push_back(CHAR_HYPHEN);
        put_hex(4);
        name_buf.push_back(CHAR_HYPHEN);
        put_hex(12);
    endtask

    task automatic put_tag(input logic is_pid, input int ndig);
        put_str(is_pid ? "BPID:" : "BCID:");
        put_hex(ndig);
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++)
            name_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic flush_name();
        name_byte_t b;
        if (name_buf.size() == 0)
            name_buf.push_back(CHAR_SPACE);
        for (int i = 0; i < name_buf.size(); i++)
        begin
            b.ch = name_buf[i];
            b.last = (i == name_buf.size() - 1);
            pending_q.push_back(b);
        end
        name_buf.delete();
        names_built++;
    endtask

    task automatic build_random_name();
        int kind;
        int order [3];
        int j;
        int t;
        logic with_tags;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            put_sep();
        if (kind <= 6)
        begin
            with_tags = ($urandom_range(0, 4) != 0);
            order[0] = 0;
            order[1] = 1;
            order[2] = 2;
            for (int i = 2; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                t = order[i];
                order[i] = order[j];
                order[j] = t;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (order[i] == 0)
                    put_uuid();
                else if (with_tags)
                    put_tag(order[i] == 2, 4);
                if (i < 2)
                    put_sep();
            end
            if (kind == 5)
            begin
                put_sep();
                case ($urandom_range(0, 3))
                    0: put_uuid();
                    1: put_tag(1'b0, 4);
                    2: put_tag(1'b1, 4);
                    default: put_tag(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 3 : 5);
                endcase
            end
            if (kind == 6)
                name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(0, 255));
            // zero byte cuts the text short, junk after it is ignored
            if ($urandom_range(0, 7) == 0)
            begin
                name_buf.insert($urandom_range(0, name_buf.size()), CHAR_NUL);
                put_noise($urandom_range(0, 6));
            end
        end
        else if (kind == 7)
            put_noise($urandom_range(1, 24));
        else if (kind == 8)
        begin
            put_uuid();
            put_sep();
            put_hex($urandom_range(30, 80));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: put_str("bcid:12ab");
                1: put_str("BPID:1g34");
                2: put_str("BCID");
                default: put_hex($urandom_range(1, 40));
            endcase
            put_sep();
            put_uuid();
        end
        if ($urandom_range(0, 1) == 1)
            put_sep();
        flush_name();
    endtask

    initial
    begin
        clear_parse();

        // uuid alone, upper case
        put_str("0123ABCD-EF01-4567-89AB-CDEF01234567");
        flush_name();
        // uuid with both tags, mixed case, leading and inner white space
        put_str(" 89abcdef-0123-4567-89ab-cdef01234567\vBCID:00fF\tBPID:FfFf\f");
        flush_name();
        // extreme tag values
        put_str("BPID:0000\rBCID:ffff\nffffffff-ffff-ffff-ffff-ffffffffffff");
        flush_name();
        // only one tag
        put_str("00000000-0000-0000-0000-000000000000 BCID:1234");
        flush_name();
        // tags but no uuid
        put_str("BCID:1234 BPID:5678");
        flush_name();
        // second uuid
        put_str("11111111-2222-3333-4444-555555555555 11111111-2222-3333-4444-555555555555");
        flush_name();
        // repeated tag
        put_str("aaaaaaaa-bbbb-cccc-dddd-eeeeeeeeeeee BCID:0001 BCID:0002 BPID:0003");
        flush_name();
        // zero byte ends the text, high bytes after it are ignored
        put_str("12345678-9abc-def0-1234-56789abcdef0");
        name_buf.push_back(CHAR_NUL);
        name_buf.push_back(8'hff);
        name_buf.push_back(8'h80);
        flush_name();
        // overlong token
        put_uuid();
        put_sep();
        for (int i = 0; i < 70; i++)
            name_buf.push_back(CHAR_UC_A);
        flush_name();
        // single byte names
        name_buf.push_back(8'hff);
        flush_name();
        name_buf.push_back(CHAR_NUL);
        flush_name();

        while (pending_q.size() < MIN_BYTES || names_built < MIN_NAMES)
            build_random_name();
        stim_total = pending_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (!(items_done == stim_total && verdict_q.size() == 0))
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && verdict_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    int tx_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            s_axis_tlast <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            logic       busy;
            int         g;
            name_byte_t nx;
            busy = s_axis_tvalid;
            g = tx_gap;
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_item(s_axis_tdata, s_axis_tlast);
                items_done++;
                busy = 1'b0;
                // every third stretch of items goes back to back
                g = ((items_done / 200) % 3 == 2) ? 0 : $urandom_range(0, 12);
            end
            if (!busy)
            begin
                if (g > 0)
                begin
                    g--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    nx = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nx.ch;
                    s_axis_tlast <= nx.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            tx_gap <= g;
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    task automatic cmp_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= 10)
                $display("verdict %0d %s mismatch: expected %h got %h",
                         verdicts_seen, fname, want, got);
        end
    endtask

    task automatic check_verdict(input logic [OUT_DATA_W-1:0] d);
        verdict_t want;
        if (verdict_q.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("verdict %0d arrived with none expected: %h", verdicts_seen, d);
        end
        else
        begin
            want = verdict_q.pop_front();
            cmp_field("status", 64'(want.status), 64'(d[0]));
            cmp_field("uuid_high", want.uuid_high, d[64:1]);
            cmp_field("uuid_low", want.uuid_low, d[128:65]);
            cmp_field("has_cid_pid", 64'(want.has_cid_pid), 64'(d[129]));
            cmp_field("company_id", 64'(want.company_id), 64'(d[145:130]));
            cmp_field("product_id", 64'(want.product_id), 64'(d[161:146]));
        end
    endtask

    int rx_wait = 0;
    int hold_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
            hold_left <= 0;
        end
        else
        begin
            int w;
            int h;
            w = rx_wait;
            h = hold_left;
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_verdict(m_axis_tdata);
                verdicts_seen++;
                w = ((verdicts_seen / 8) % 3 == 2) ? 0 : $urandom_range(0, 12);
                // long hold-off so the parser backs up on its input
                if (verdicts_seen == 3)
                    h = HOLD_CYCLES;
            end
            else if (h > 0)
                h--;
            else if (w > 0)
                w--;
            m_axis_tready <= (h == 0 && w == 0);
            rx_wait <= w;
            hold_left <= h;
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: filelist.f
design/cnp_pkg.sv
design/cnp_char_class.sv
design/cnp_token_parser.sv
design/cert_common_name_parser_top.sv
tb/cert_common_name_parser_top_tb.sv
